// ----- rtl/core/obt2d_pkg.sv -----
package obt2d_pkg;

	localparam int MAX_CANDIDATES_DEF = 1024;

	localparam int COORD_W = 32;
	localparam int OPND_W  = 33;
	localparam int PROD_W  = 2 * OPND_W;
	localparam int BIAS_W  = 48;
	localparam int ACC_W   = 67;
	localparam int THR_W   = 31;
	localparam int SQ_W    = 63;
	localparam int DIV_W   = 48;
	localparam int QUO_W   = 17;
	localparam int NRM_W   = 18;
	localparam int KCNT_W  = 11;
	localparam int KCNT_MAX = 2047;
	localparam int NUM_TESTS = 12;

	localparam logic [1:0] ACT_LOAD_N = 2'd0;
	localparam logic [1:0] ACT_LOAD_M = 2'd1;
	localparam logic [1:0] ACT_TEST   = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] ex;
		logic signed [COORD_W-1:0] ey;
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] w;
	} surf_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] nx;
		logic signed [COORD_W-1:0] ny;
		logic signed [COORD_W-1:0] w;
	} line_t;

	typedef struct packed {
		logic                     vld;
		logic                     clr;
		logic signed [OPND_W-1:0] a;
		logic signed [OPND_W-1:0] b;
		logic signed [BIAS_W-1:0] bias;
	} mac_op_t;

endpackage

// ----- rtl/core/obt2d_mac.sv -----
module obt2d_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  obt2d_pkg::mac_op_t                   op,
	output logic signed [obt2d_pkg::ACC_W-1:0]   acc
);
	import obt2d_pkg::*;

	logic                     vld_s1;
	logic                     clr_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [BIAS_W-1:0] bias_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= op.vld;
		end
	end

	// product registered first, accumulated into acc_q in the next cycle
	always_ff @(posedge clk) begin
		prod_s1 <= $signed(op.a) * $signed(op.b);
		clr_s1  <= op.clr;
		bias_s1 <= op.bias;
		if (vld_s1) begin
			acc_q <= (clr_s1 ? ACC_W'(bias_s1) : acc_q) + ACC_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/core/obstruction_box_test_2d.sv -----
// Box test for 2D view obstruction between two segments N and M.
// Input channel: item_valid / item_stall carry one item (action, surf_id,
// endpoints, line normal and offset, last_candidate). Action 0 loads N,
// 1 loads M, 2 tests a candidate; action 3 is taken and ignored.
// Output channel: res_valid / res_stall carry one result per candidate and
// none for loads. cfg_write / cfg_data set sign_threshold; the user is to
// write it only while idle, which the block itself does not enforce.
// One item is worked at a time on a shared multiply-accumulate unit.
// A load rebuilds both sides: per side, setup and multiply steps on the MAC,
// then, unless the side is degenerate, 32 square root steps and 2 x 17
// divide steps. A candidate takes 12 sign tests on the MAC; once the view is
// blocked a candidate skips the tests and goes straight to its result.
// The result sits in an output register; the next item is accepted while
// it waits. A stalled result holds until taken, and a finished candidate
// waits for the output register to free up.
// Reset clears both surfaces, the sides, the threshold and the list flags.
module obstruction_box_test_2d #(
	parameter int MAX_CANDIDATES = obt2d_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [obt2d_pkg::THR_W-1:0]          cfg_data,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [1:0]                           action,
	input  logic [15:0]                          surf_id,
	input  logic signed [obt2d_pkg::COORD_W-1:0] start_x,
	input  logic signed [obt2d_pkg::COORD_W-1:0] start_y,
	input  logic signed [obt2d_pkg::COORD_W-1:0] end_x,
	input  logic signed [obt2d_pkg::COORD_W-1:0] end_y,
	input  logic signed [obt2d_pkg::COORD_W-1:0] normal_x,
	input  logic signed [obt2d_pkg::COORD_W-1:0] normal_y,
	input  logic signed [obt2d_pkg::COORD_W-1:0] normal_offset,
	input  logic                                 last_candidate,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [15:0]                          result_id,
	output logic                                 kept,
	output logic signed [1:0]                    orientation,
	output logic                                 view_blocked,
	output logic [obt2d_pkg::KCNT_W-1:0]         kept_count,
	output logic                                 done_res
);
	import obt2d_pkg::*;

	localparam int CAP_INT = (MAX_CANDIDATES < KCNT_MAX) ? MAX_CANDIDATES : KCNT_MAX;
	localparam logic [KCNT_W-1:0] KEPT_CAP = KCNT_W'(CAP_INT);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SIDE_PREP, ST_SQ_X, ST_SQ_Y, ST_SQ_W1, ST_SQ_W2,
		ST_THR_M, ST_THR_W1, ST_THR_W2, ST_SQRT, ST_DIV,
		ST_W_M1, ST_W_M2, ST_W_W1, ST_W_W2,
		ST_TEST_M1, ST_TEST_M2, ST_TEST_W1, ST_TEST_W2, ST_FINISH
	} state_t;

	state_t               state_q;
	logic [THR_W-1:0]     thr_q;
	surf_t                near_q, far_q, cand_q;
	line_t                sa_q, sb_q;
	logic                 dega_q, degb_q, blk_q;
	logic [KCNT_W-1:0]    kcnt_q;
	logic [15:0]          id_q;
	logic                 last_q;
	logic                 side_q;
	logic                 dsel_q;
	logic [3:0]           tst_q;
	logic [NUM_TESTS-1:0] pos_q, neg_q;
	logic [4:0]           cnt_q;

	logic signed [COORD_W-1:0] hx_q, hy_q, mx_q, my_q;
	logic                      big_q;
	logic [SQ_W-1:0]           sq_q, v_q, res_q, bit_q;
	logic [COORD_W-1:0]        len_q;
	logic [DIV_W-1:0]          rem_q, dsh_q;
	logic [QUO_W-1:0]          quo_q;
	logic signed [NRM_W-1:0]   nx_q, ny_q;

	logic                 res_valid_q;
	logic [15:0]          result_id_q;
	logic                 kept_q;
	logic signed [1:0]    orient_q;
	logic                 vblk_q;
	logic [KCNT_W-1:0]    kcnt_out_q;
	logic                 done_q;

	mac_op_t                  op;
	logic signed [ACC_W-1:0]  acc;

	obt2d_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.acc    (acc)
	);

	logic accept;
	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);

	// side geometry
	logic signed [COORD_W-1:0] x1, y1, x2, y2;
	logic signed [COORD_W:0]   dx, dy, adx, ady, hdx, hdy, smx, smy;
	logic                      big_n;

	always_comb begin
		x1 = side_q ? far_q.ex : near_q.ex;
		y1 = side_q ? far_q.ey : near_q.ey;
		x2 = side_q ? near_q.sx : far_q.sx;
		y2 = side_q ? near_q.sy : far_q.sy;
		dx = (COORD_W+1)'(x2) - (COORD_W+1)'(x1);
		dy = (COORD_W+1)'(y2) - (COORD_W+1)'(y1);
		adx = dx[COORD_W] ? -dx : dx;
		ady = dy[COORD_W] ? -dy : dy;
		big_n = adx[COORD_W] | adx[COORD_W-1] | ady[COORD_W] | ady[COORD_W-1];
		// halve toward zero
		hdx = (dx + $signed({{COORD_W{1'b0}}, dx[COORD_W]})) >>> 1;
		hdy = (dy + $signed({{COORD_W{1'b0}}, dy[COORD_W]})) >>> 1;
		smx = (COORD_W+1)'(x1) + (COORD_W+1)'(x2);
		smy = (COORD_W+1)'(y1) + (COORD_W+1)'(y2);
	end

	// square root step
	logic [SQ_W-1:0]    trial, res_n;
	logic               sq_ge;
	logic [COORD_W-1:0] len_n;

	always_comb begin
		trial = res_q + bit_q;
		sq_ge = (v_q >= trial);
		res_n = sq_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
		len_n = (res_n[COORD_W-1:0] == '0) ? COORD_W'(1) : res_n[COORD_W-1:0];
	end

	// divide step
	logic                    dv_ge;
	logic [QUO_W-1:0]        quo_n;
	logic signed [NRM_W-1:0] qpos;
	logic [COORD_W-1:0]      abs_hx, abs_hy;

	always_comb begin
		dv_ge  = (rem_q >= dsh_q);
		quo_n  = {quo_q[QUO_W-2:0], dv_ge};
		qpos   = $signed({1'b0, quo_n});
		abs_hx = hx_q[COORD_W-1] ? COORD_W'(-hx_q) : COORD_W'(hx_q);
		abs_hy = hy_q[COORD_W-1] ? COORD_W'(-hy_q) : COORD_W'(hy_q);
	end

	// line offset from the midpoint
	logic signed [ACC_W-1:0]   negw, wsh;
	logic signed [COORD_W-1:0] w_sat;

	always_comb begin
		negw = -acc;
		wsh  = negw >>> 16;
		if (wsh[ACC_W-1:COORD_W-1] == '0 || wsh[ACC_W-1:COORD_W-1] == '1) begin
			w_sat = wsh[COORD_W-1:0];
		end else begin
			w_sat = wsh[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

	// sign test operands
	line_t                     cl, nl, ml, tline;
	logic signed [COORD_W-1:0] tpx, tpy;

	always_comb begin
		cl = '{nx: cand_q.nx, ny: cand_q.ny, w: cand_q.w};
		nl = '{nx: near_q.nx, ny: near_q.ny, w: near_q.w};
		ml = '{nx: far_q.nx,  ny: far_q.ny,  w: far_q.w};
		tline = cl;
		tpx = cand_q.sx;
		tpy = cand_q.sy;
		case (tst_q)
			4'd0: begin tline = cl; tpx = near_q.sx; tpy = near_q.sy; end
			4'd1: begin tline = cl; tpx = near_q.ex; tpy = near_q.ey; end
			4'd2: begin tline = cl; tpx = far_q.sx;  tpy = far_q.sy;  end
			4'd3: begin tline = cl; tpx = far_q.ex;  tpy = far_q.ey;  end
			4'd4: begin tline = sa_q; tpx = cand_q.sx; tpy = cand_q.sy; end
			4'd5: begin tline = sa_q; tpx = cand_q.ex; tpy = cand_q.ey; end
			4'd6: begin tline = sb_q; tpx = cand_q.sx; tpy = cand_q.sy; end
			4'd7: begin tline = sb_q; tpx = cand_q.ex; tpy = cand_q.ey; end
			4'd8: begin tline = nl; tpx = cand_q.sx; tpy = cand_q.sy; end
			4'd9: begin tline = nl; tpx = cand_q.ex; tpy = cand_q.ey; end
			4'd10: begin tline = ml; tpx = cand_q.sx; tpy = cand_q.sy; end
			4'd11: begin tline = ml; tpx = cand_q.ex; tpy = cand_q.ey; end
			default: begin tline = cl; tpx = cand_q.sx; tpy = cand_q.sy; end
		endcase
	end

	// MAC issue
	always_comb begin
		op = '0;
		case (state_q)
			ST_SQ_X: begin
				op.vld = 1'b1; op.clr = 1'b1;
				op.a = OPND_W'(hx_q); op.b = OPND_W'(hx_q);
			end
			ST_SQ_Y: begin
				op.vld = 1'b1;
				op.a = OPND_W'(hy_q); op.b = OPND_W'(hy_q);
			end
			ST_THR_M: begin
				op.vld = 1'b1; op.clr = 1'b1;
				op.a = $signed({2'b00, thr_q}); op.b = $signed({2'b00, thr_q});
			end
			ST_W_M1: begin
				op.vld = 1'b1; op.clr = 1'b1;
				op.a = OPND_W'(mx_q); op.b = OPND_W'(nx_q);
			end
			ST_W_M2: begin
				op.vld = 1'b1;
				op.a = OPND_W'(my_q); op.b = OPND_W'(ny_q);
			end
			ST_TEST_M1: begin
				op.vld = 1'b1; op.clr = 1'b1;
				op.a = OPND_W'(tline.nx); op.b = OPND_W'(tpx);
				op.bias = {tline.w, 16'h0};
			end
			ST_TEST_M2: begin
				op.vld = 1'b1;
				op.a = OPND_W'(tline.ny); op.b = OPND_W'(tpy);
			end
			default: op = '0;
		endcase
	end

	// sign of the accumulated dot product
	logic signed [ACC_W-1:0] thr_sh;
	logic                    t_pos, t_neg, degen_n;

	always_comb begin
		thr_sh  = $signed({{(ACC_W-THR_W-16){1'b0}}, thr_q, 16'h0});
		t_pos   = (acc > thr_sh);
		t_neg   = (acc < -thr_sh);
		degen_n = !big_q && (sq_q <= acc[SQ_W-1:0]);
	end

	// candidate decision
	logic [NUM_TESTS-1:0] pm, nm, le, ge;
	logic                 all_right, all_left, drop, blocks, blk_cond;
	logic signed [1:0]    orient_n;
	logic [KCNT_W-1:0]    kinc;

	always_comb begin
		pm = pos_q;
		nm = neg_q;
		if (dega_q) begin pm[5:4] = 2'b00; nm[5:4] = 2'b00; end
		if (degb_q) begin pm[7:6] = 2'b00; nm[7:6] = 2'b00; end
		le = ~pm;
		ge = ~nm;
		all_right = (pm[3:0] == 4'b0000);
		all_left  = (nm[3:0] == 4'b0000);
		drop = (!dega_q && le[4] && le[5]) || (!degb_q && le[6] && le[7]) ||
			(le[8] && le[9]) || (le[10] && le[11]) || all_right || all_left;
		if (dega_q) begin
			blk_cond = le[6] && le[8] && le[10];
		end else if (degb_q) begin
			blk_cond = le[5] && le[9] && le[11];
		end else begin
			blk_cond = le[5] && le[7];
		end
		blocks = le[0] && le[1] && ge[2] && ge[3] && blk_cond;
		orient_n = $signed({1'b0, pm[0] | pm[1]}) - $signed({1'b0, pm[2] | pm[3]});
		kinc = (kcnt_q < KEPT_CAP) ? kcnt_q + KCNT_W'(1) : kcnt_q;
	end

	logic out_free;
	assign out_free = !res_valid_q || !res_stall;

	// control, model state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= '0;
			near_q      <= '0;
			far_q       <= '0;
			sa_q        <= '0;
			sb_q        <= '0;
			dega_q      <= 1'b0;
			degb_q      <= 1'b0;
			blk_q       <= 1'b0;
			kcnt_q      <= '0;
			side_q      <= 1'b0;
			dsel_q      <= 1'b0;
			tst_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			result_id_q <= '0;
			kept_q      <= 1'b0;
			orient_q    <= '0;
			vblk_q      <= 1'b0;
			kcnt_out_q  <= '0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_write) begin
				thr_q <= cfg_data;
			end
			// drop a taken result unless a new one loads this cycle
			if (res_valid_q && !res_stall && state_q != ST_FINISH) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == ACT_LOAD_N || action == ACT_LOAD_M) begin
							if (action == ACT_LOAD_N) begin
								near_q <= '{start_x, start_y, end_x, end_y,
									normal_x, normal_y, normal_offset};
							end else begin
								far_q <= '{start_x, start_y, end_x, end_y,
									normal_x, normal_y, normal_offset};
							end
							blk_q   <= 1'b0;
							kcnt_q  <= '0;
							side_q  <= 1'b0;
							state_q <= ST_SIDE_PREP;
						end else if (action == ACT_TEST) begin
							tst_q   <= '0;
							state_q <= blk_q ? ST_FINISH : ST_TEST_M1;
						end
					end
				end
				ST_SIDE_PREP: state_q <= ST_SQ_X;
				ST_SQ_X:      state_q <= ST_SQ_Y;
				ST_SQ_Y:      state_q <= ST_SQ_W1;
				ST_SQ_W1:     state_q <= ST_SQ_W2;
				ST_SQ_W2:     state_q <= ST_THR_M;
				ST_THR_M:     state_q <= ST_THR_W1;
				ST_THR_W1:    state_q <= ST_THR_W2;
				ST_THR_W2: begin
					if (degen_n) begin
						if (side_q) begin
							sb_q <= '0; degb_q <= 1'b1; state_q <= ST_IDLE;
						end else begin
							sa_q <= '0; dega_q <= 1'b1; side_q <= 1'b1;
							state_q <= ST_SIDE_PREP;
						end
					end else begin
						cnt_q   <= 5'd31;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						cnt_q   <= 5'(QUO_W - 1);
						dsel_q  <= 1'b0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						if (!dsel_q) begin
							cnt_q  <= 5'(QUO_W - 1);
							dsel_q <= 1'b1;
						end else begin
							state_q <= ST_W_M1;
						end
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				ST_W_M1: state_q <= ST_W_M2;
				ST_W_M2: state_q <= ST_W_W1;
				ST_W_W1: state_q <= ST_W_W2;
				ST_W_W2: begin
					if (side_q) begin
						sb_q   <= '{nx: COORD_W'(nx_q), ny: COORD_W'(ny_q), w: w_sat};
						degb_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						sa_q   <= '{nx: COORD_W'(nx_q), ny: COORD_W'(ny_q), w: w_sat};
						dega_q <= 1'b0;
						side_q <= 1'b1;
						state_q <= ST_SIDE_PREP;
					end
				end
				ST_TEST_M1: state_q <= ST_TEST_M2;
				ST_TEST_M2: state_q <= ST_TEST_W1;
				ST_TEST_W1: state_q <= ST_TEST_W2;
				ST_TEST_W2: begin
					if (tst_q == 4'(NUM_TESTS - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						tst_q   <= tst_q + 4'd1;
						state_q <= ST_TEST_M1;
					end
				end
				ST_FINISH: begin
					// hold until the output register frees up
					if (out_free) begin
						res_valid_q <= 1'b1;
						result_id_q <= id_q;
						done_q      <= last_q;
						vblk_q      <= blk_q || (!drop && blocks);
						if (!blk_q && !drop && !blocks) begin
							kept_q     <= 1'b1;
							orient_q   <= orient_n;
							kcnt_out_q <= kinc;
						end else begin
							kept_q     <= 1'b0;
							orient_q   <= '0;
							kcnt_out_q <= kcnt_q;
						end
						if (last_q) begin
							blk_q  <= 1'b0;
							kcnt_q <= '0;
						end else if (!blk_q && !drop) begin
							if (blocks) begin
								blk_q <= 1'b1;
							end else begin
								kcnt_q <= kinc;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cand_q <= '{start_x, start_y, end_x, end_y,
						normal_x, normal_y, normal_offset};
					id_q   <= surf_id;
					last_q <= last_candidate;
				end
			end
			ST_SIDE_PREP: begin
				big_q <= big_n;
				hx_q  <= big_n ? hdx[COORD_W-1:0] : dx[COORD_W-1:0];
				hy_q  <= big_n ? hdy[COORD_W-1:0] : dy[COORD_W-1:0];
				mx_q  <= smx[COORD_W:1];
				my_q  <= smy[COORD_W:1];
			end
			ST_SQ_W2: sq_q <= acc[SQ_W-1:0];
			ST_THR_W2: begin
				v_q   <= sq_q;
				res_q <= '0;
				bit_q <= {1'b1, {(SQ_W-1){1'b0}}};
			end
			ST_SQRT: begin
				if (sq_ge) begin
					v_q <= v_q - trial;
				end
				res_q <= res_n;
				bit_q <= bit_q >> 2;
				if (cnt_q == '0) begin
					len_q <= len_n;
					rem_q <= {abs_hy, 16'h0};
					dsh_q <= {len_n, 16'h0};
					quo_q <= '0;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0 && !dsel_q) begin
					nx_q  <= hy_q[COORD_W-1] ? qpos : -qpos;
					rem_q <= {abs_hx, 16'h0};
					dsh_q <= {len_q, 16'h0};
					quo_q <= '0;
				end else begin
					rem_q <= dv_ge ? rem_q - dsh_q : rem_q;
					dsh_q <= dsh_q >> 1;
					quo_q <= quo_n;
					if (cnt_q == '0) begin
						ny_q <= hx_q[COORD_W-1] ? -qpos : qpos;
					end
				end
			end
			ST_TEST_W2: begin
				pos_q[tst_q] <= t_pos;
				neg_q[tst_q] <= t_neg;
			end
			default: begin
			end
		endcase
	end

	assign res_valid    = res_valid_q;
	assign result_id    = result_id_q;
	assign kept         = kept_q;
	assign orientation  = orient_q;
	assign view_blocked = vblk_q;
	assign kept_count   = kcnt_out_q;
	assign done_res     = done_q;

	a_kept_not_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kept |-> !view_blocked)
		else $error("kept candidate reported with view blocked");

	a_orient_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !kept |-> orientation == 2'sb00)
		else $error("orientation set on a candidate that is not kept");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> kept_count <= KEPT_CAP)
		else $error("kept count beyond its cap");

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dega_q |-> sa_q == '0)
		else $error("degenerate side A carries a nonzero line");

endmodule
